[rtl/assert_macros.svh]
// assertion macros shared by the matcher rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define LWM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lwm assertion failed");
`define LWM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("lwm assertion failed");
`else
`define LWM_ASSERT(lbl, clk, rst_n, prop)
`define LWM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/lwm_pkg.sv]
// types and constants for the like-pattern matcher
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package lwm_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_TEXT   = 2'd2;
    localparam logic [1:0] CMD_END    = 2'd3;

    localparam logic [7:0] WILD_RUN = 8'h25;
    localparam logic [7:0] WILD_ONE = 8'h5F;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic is_match;
        logic truncated;
    } out_item_t;

    // broadcast to every cell in the row
    typedef struct packed {
        logic       rearm;
        logic       advance;
        logic [7:0] char_code;
    } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/lwm_cell.sv]
// one pattern position: its pattern byte and its active bit
// depends on lwm_pkg
`timescale 1ns / 1ps
`default_nettype none
module lwm_cell
    import lwm_pkg::*;
#(
    parameter logic ACT_AT_RESET = 1'b0
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       in_use,
    input  wire logic       wr_sel,
    input  wire logic       fwd_in,
    input  wire logic       carry_in,
    output logic            fwd_out,
    output logic            carry_out,
    output logic            act
);

    logic [7:0] byte_reg;
    logic [7:0] byte_eff;
    logic       act_reg;
    logic       act_next;
    logic       is_run;
    logic       hit;
    logic       closed;

    // a byte written this cycle is already seen by the rearm pass
    assign byte_eff = wr_sel ? ctrl.char_code : byte_reg;
    assign is_run   = in_use && (byte_eff == WILD_RUN);
    assign hit      = (byte_eff == WILD_ONE) || (byte_eff == ctrl.char_code);

    // consumed text byte moves the active mark one position right
    assign fwd_out = ctrl.advance && act_reg && in_use && !is_run && hit;

    // a run wildcard keeps itself and passes activity on as a carry
    assign closed    = fwd_in || carry_in || (ctrl.advance && act_reg && is_run);
    assign carry_out = closed && is_run;

    assign act_next = (ctrl.rearm || ctrl.advance) ? closed : act_reg;
    assign act      = act_reg;

    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            byte_reg <= ctrl.char_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= ACT_AT_RESET;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

endmodule
`default_nettype wire

[rtl/lwm_result_buf.sv]
// two-entry result buffer: output register plus skid entry
// depends on lwm_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lwm_result_buf
    import lwm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire out_item_t push_item,
    output logic           has_room,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    logic      out_valid_reg;
    logic      out_valid_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    out_item_t skid_item_reg;
    out_item_t skid_item_next;
    logic      pop;

    assign pop       = out_valid_reg && out_ready;
    assign has_room  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_item_next   = skid_item_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_item_next  = push_item;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_item_next  = push_item;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    `LWM_ASSERT(a_skid_behind_out, clk, rst_n, skid_valid_reg |-> out_valid_reg)
    `LWM_ASSERT(a_push_to_skid, clk, rst_n, push && out_valid_reg && !out_ready |=> skid_valid_reg)
    `LWM_ASSERT(a_skid_drains, clk, rst_n, pop && skid_valid_reg |=> out_valid_reg && !skid_valid_reg)

endmodule
`default_nettype wire

[rtl/sql_like_wildcard_matcher.sv]
// channel | direction | payload     | handshake
// in      | request   | in_item_t   | in_valid / in_ready
// out     | result    | out_item_t  | out_valid / out_ready
//
// one request per cycle of every kind; an end-of-text request's result is registered
// in the result buffer. the cycle time is set by the carry through runs of '%' across
// the row of MAX_PATTERN cells. reset leaves an empty pattern with only position zero
// active. in_ready drops only while both result entries are waiting to be taken.
// depends on lwm_pkg, lwm_cell, lwm_result_buf
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sql_like_wildcard_matcher
    import lwm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic                   in_acc;
    logic                   is_append;
    logic                   room;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   last_reg;
    logic                   last_next;
    cell_ctrl_t             ctrl;
    logic [MAX_PATTERN-1:0] in_use;
    logic [MAX_PATTERN-1:0] wr_sel;
    logic [MAX_PATTERN:0]   fwd;
    logic [MAX_PATTERN:0]   carry;
    logic [MAX_PATTERN:0]   act_vec;
    logic                   push;
    out_item_t              push_item;
    logic                   has_room;

    assign in_ready  = has_room;
    assign in_acc    = in_valid && in_ready;
    assign is_append = in_acc && (in_item.cmd == CMD_APPEND);
    assign room      = (len_reg != LEN_W'(MAX_PATTERN));

    assign ctrl.rearm     = in_acc && (in_item.cmd != CMD_TEXT);
    assign ctrl.advance   = in_acc && (in_item.cmd == CMD_TEXT);
    assign ctrl.char_code = in_item.char_code;

    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (in_acc)
        begin
            case (in_item.cmd)
                CMD_CLEAR:
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                end
                CMD_APPEND:
                begin
                    if (room)
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                default:
                begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    // the row of cells; position zero starts the pass on a rearm
    assign fwd[0]   = ctrl.rearm;
    assign carry[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < MAX_PATTERN; i++)
        begin : g_cell
            assign in_use[i] = LEN_W'(i) < len_next;
            assign wr_sel[i] = is_append && (len_reg == LEN_W'(i));

            lwm_cell #(
                .ACT_AT_RESET (i == 0)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .in_use    (in_use[i]),
                .wr_sel    (wr_sel[i]),
                .fwd_in    (fwd[i]),
                .carry_in  (carry[i]),
                .fwd_out   (fwd[i+1]),
                .carry_out (carry[i+1]),
                .act       (act_vec[i])
            );
        end
    endgenerate

    // position past the last cell; it holds the match when the pattern is full
    assign last_next           = (ctrl.rearm || ctrl.advance) ?
                                 (fwd[MAX_PATTERN] || carry[MAX_PATTERN]) : last_reg;
    assign act_vec[MAX_PATTERN] = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
            last_reg <= last_next;
        end
    end

    assign push               = in_acc && (in_item.cmd == CMD_END);
    assign push_item.is_match  = act_vec[len_reg];
    assign push_item.truncated = ovf_reg;

    lwm_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    `LWM_ASSERT(a_len_in_range, clk, rst_n, len_reg <= LEN_W'(MAX_PATTERN))
    `LWM_ASSERT(a_clear_resets, clk, rst_n, in_acc && in_item.cmd == CMD_CLEAR |=> !ovf_reg && len_reg == '0)
    `LWM_ASSERT(a_rearm_start, clk, rst_n, ctrl.rearm |=> act_vec[0])

endmodule
`default_nettype wire

[dv/tb_sql_like_wildcard_matcher.sv]
// testbench for sql_like_wildcard_matcher: directed table, then random pattern/text sequences
// depends on lwm_pkg and the matcher rtl; self-checking against its own nfa predictor
`timescale 1ns / 1ps
module tb_sql_like_wildcard_matcher
    import lwm_pkg::*;
();

    localparam int MAXP        = 32;
    localparam int RAND_ITEMS  = 1000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DIR_ROWS    = 25;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    sql_like_wildcard_matcher #(.MAX_PATTERN(MAXP)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // predictor state
    logic [7:0]    pat_mem [0:MAXP-1];
    int unsigned   pat_len;
    logic [MAXP:0] live_pos;
    logic          pat_overflow;

    // tag per request: {typed, match, truncated}; typed rows carry their own answer
    logic [2:0]    tag_q [$];
    out_item_t     verdict_q [$];

    int  send_idle;
    int  rx_stall;
    bit  hold_ask;
    int  sent_count;
    int  fail_count;
    int  cycle_count;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
        logic [5:0] reps;
        logic       typed;
        logic       want_match;
        logic       want_trunc;
    } dir_row_t;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{CMD_END,    8'h00,    6'd1,  1'b1, 1'b1, 1'b0},  // empty pattern, empty text
        '{CMD_TEXT,   8'h00,    6'd1,  1'b0, 1'b0, 1'b0},
        '{CMD_END,    8'h00,    6'd1,  1'b1, 1'b0, 1'b0},  // empty pattern, one byte
        '{CMD_APPEND, WILD_RUN, 6'd1,  1'b0, 1'b0, 1'b0},
        '{CMD_END,    8'hFF,    6'd1,  1'b1, 1'b1, 1'b0},  // only '%', empty text
        '{CMD_APPEND, 8'h00,    6'd1,  1'b0, 1'b0, 1'b0},
        '{CMD_TEXT,   8'hFF,    6'd1,  1'b0, 1'b0, 1'b0},
        '{CMD_TEXT,   8'h00,    6'd1,  1'b0, 1'b0, 1'b0},
        '{CMD_END,    8'h00,    6'd1,  1'b1, 1'b1, 1'b0},
        '{CMD_APPEND, WILD_ONE, 6'd1,  1'b0, 1'b0, 1'b0},
        '{CMD_TEXT,   WILD_RUN, 6'd1,  1'b0, 1'b0, 1'b0},  // wildcards in text are plain bytes
        '{CMD_TEXT,   8'h00,    6'd1,  1'b0, 1'b0, 1'b0},
        '{CMD_TEXT,   WILD_ONE, 6'd1,  1'b0, 1'b0, 1'b0},
        '{CMD_END,    8'h00,    6'd1,  1'b0, 1'b0, 1'b0},
        '{CMD_TEXT,   8'h00,    6'd1,  1'b0, 1'b0, 1'b0},
        '{CMD_TEXT,   8'h7F,    6'd1,  1'b0, 1'b0, 1'b0},
        '{CMD_CLEAR,  8'hFF,    6'd1,  1'b0, 1'b0, 1'b0},  // drops the partial text
        '{CMD_END,    8'h00,    6'd1,  1'b1, 1'b1, 1'b0},
        '{CMD_APPEND, 8'hFF,    6'd33, 1'b0, 1'b0, 1'b0},  // one byte past capacity
        '{CMD_TEXT,   8'hFF,    6'd32, 1'b0, 1'b0, 1'b0},
        '{CMD_END,    8'h00,    6'd1,  1'b1, 1'b1, 1'b1},
        '{CMD_TEXT,   8'hFF,    6'd1,  1'b0, 1'b0, 1'b0},
        '{CMD_END,    8'h00,    6'd1,  1'b1, 1'b0, 1'b1},
        '{CMD_CLEAR,  8'h00,    6'd1,  1'b0, 1'b0, 1'b0},
        '{CMD_END,    8'h00,    6'd1,  1'b1, 1'b1, 1'b0}   // clear drops the flag
    };

    // empty matches: '%' passes activity on to the next position
    function automatic void close_runs();
        for (int i = 0; i < pat_len; i++)
        begin
            if (live_pos[i] && pat_mem[i] == WILD_RUN)
                live_pos[i+1] = 1'b1;
        end
    endfunction

    function automatic void rearm_nfa();
        live_pos = '0;
        live_pos[0] = 1'b1;
        close_runs();
    endfunction

    function automatic void step_text(input logic [7:0] c);
        logic [MAXP:0] nxt;
        nxt = '0;
        for (int i = 0; i < pat_len; i++)
        begin
            if (live_pos[i])
            begin
                if (pat_mem[i] == WILD_RUN)
                    nxt[i] = 1'b1;
                else if (pat_mem[i] == WILD_ONE || pat_mem[i] == c)
                    nxt[i+1] = 1'b1;
            end
        end
        live_pos = nxt;
        close_runs();
    endfunction

    // returns 1 when the request produces a verdict
    function automatic bit like_predict(input in_item_t req, output out_item_t verdict);
        verdict = '0;
        case (req.cmd)
            CMD_CLEAR:
            begin
                pat_len = 0;
                pat_overflow = 1'b0;
                rearm_nfa();
                return 1'b0;
            end
            CMD_APPEND:
            begin
                if (pat_len < MAXP)
                begin
                    pat_mem[pat_len] = req.char_code;
                    pat_len++;
                end
                else
                    pat_overflow = 1'b1;
                rearm_nfa();
                return 1'b0;
            end
            CMD_TEXT:
            begin
                step_text(req.char_code);
                return 1'b0;
            end
            default:
            begin
                verdict.is_match  = live_pos[pat_len];
                verdict.truncated = pat_overflow;
                rearm_nfa();
                return 1'b1;
            end
        endcase
    endfunction

    task automatic send_req(input logic [1:0] cmd, input logic [7:0] ch,
                            input logic [2:0] tag);
        in_item_t req;
        req.cmd = cmd;
        req.char_code = ch;
        if (send_idle != 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        tag_q = {tag_q, tag};
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    function automatic logic [7:0] pick_pat_byte();
        int r;
        r = $urandom_range(9);
        if (r < 2)
            return WILD_RUN;
        else if (r == 2)
            return WILD_ONE;
        else if (r == 3)
            return 8'($urandom_range(255));
        return 8'h61 + 8'($urandom_range(2));
    endfunction

    // request and result bookkeeping, both in one process so order within a step is fixed
    always @(posedge clk)
    begin : monitor
        logic [2:0] tag;
        out_item_t  calc;
        out_item_t  want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("status: fail");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                tag = tag_q.pop_front();
                if (like_predict(in_item, calc))
                begin
                    if (tag[2])
                    begin
                        calc.is_match  = tag[1];
                        calc.truncated = tag[0];
                    end
                    verdict_q = {verdict_q, calc};
                end
            end
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected result: is_match %0b truncated %0b",
                             $time, out_item.is_match, out_item.truncated);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (out_item.is_match !== want.is_match)
                    begin
                        fail_count++;
                        $display("%0t is_match mismatch: expected %0b actual %0b",
                                 $time, want.is_match, out_item.is_match);
                    end
                    if (out_item.truncated !== want.truncated)
                    begin
                        fail_count++;
                        $display("%0t truncated mismatch: expected %0b actual %0b",
                                 $time, want.truncated, out_item.truncated);
                    end
                end
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ask)
            begin
                hold_ask = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_ready <= (rx_stall == 0) || ($urandom_range(99) >= rx_stall);
        end
    end

    initial
    begin : drive
        logic [7:0] pat_q [$];
        logic [7:0] txt_q [$];
        int         plen;
        int         n_txt;
        int         run_len;
        int         base;
        int         phase;
        logic [7:0] b;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        send_idle    = 0;
        rx_stall     = 0;
        hold_ask     = 1'b0;
        sent_count   = 0;
        fail_count   = 0;
        cycle_count  = 0;
        pat_len      = 0;
        pat_overflow = 1'b0;
        live_pos     = '0;
        live_pos[0]  = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            for (int k = 0; k < dir_tab[r].reps; k++)
            begin
                send_req(dir_tab[r].cmd, dir_tab[r].ch,
                         {dir_tab[r].typed, dir_tab[r].want_match, dir_tab[r].want_trunc});
            end
        end

        base = sent_count;
        hold_ask = 1'b1;
        while (sent_count - base < RAND_ITEMS)
        begin
            phase = (sent_count - base) * 4 / RAND_ITEMS;
            case (phase)
                0: begin send_idle = 0;  rx_stall = 0;  end
                1: begin send_idle = 79; rx_stall = 0;  end
                2: begin send_idle = 0;  rx_stall = 79; end
                default: begin send_idle = 9; rx_stall = 9; end
            endcase

            if ($urandom_range(9) == 0)
            begin
                // noise request
                send_req(2'($urandom_range(3)), 8'($urandom_range(255)), 3'b000);
            end
            else
            begin
                if ($urandom_range(7) != 0)
                begin
                    send_req(CMD_CLEAR, 8'($urandom_range(255)), 3'b000);
                    pat_q.delete();
                end
                plen = ($urandom_range(19) == 0) ? $urandom_range(28, 36) : $urandom_range(6);
                for (int i = 0; i < plen; i++)
                begin
                    b = pick_pat_byte();
                    send_req(CMD_APPEND, b, 3'b000);
                    pat_q = {pat_q, b};
                end
                n_txt = $urandom_range(1, 4);
                for (int t = 0; t < n_txt; t++)
                begin
                    // text built to fit the pattern, then lightly disturbed
                    txt_q.delete();
                    foreach (pat_q[i])
                    begin
                        if (pat_q[i] == WILD_RUN)
                        begin
                            run_len = $urandom_range(3);
                            for (int j = 0; j < run_len; j++)
                                txt_q = {txt_q, 8'h61 + 8'($urandom_range(2))};
                        end
                        else if (pat_q[i] == WILD_ONE)
                            txt_q = {txt_q, 8'($urandom_range(255))};
                        else if ($urandom_range(11) == 0)
                            txt_q = {txt_q, 8'h61 + 8'($urandom_range(2))};
                        else
                            txt_q = {txt_q, pat_q[i]};
                    end
                    if ($urandom_range(9) == 0 && txt_q.size() > 0)
                        void'(txt_q.pop_back());
                    if ($urandom_range(9) == 0)
                        txt_q = {txt_q, 8'($urandom_range(255))};
                    foreach (txt_q[i])
                        send_req(CMD_TEXT, txt_q[i], 3'b000);
                    if ($urandom_range(19) == 0)
                    begin
                        // pattern grows mid-text, rearming the match
                        b = pick_pat_byte();
                        send_req(CMD_APPEND, b, 3'b000);
                        pat_q = {pat_q, b};
                    end
                    send_req(CMD_END, 8'($urandom_range(255)), 3'b000);
                end
            end
        end
        in_valid <= 1'b0;

        // let the monitor book the last request before draining
        @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
